// ===== design/lcfb_pkg.sv =====
// Shared types, constants and the raised-cosine ROM for the light color fade/blink engine.
// No dependencies; the top level, the sequencer and the datapath import this package.
`default_nettype none

package lcfb_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int TIME_BITS    = 24;
    localparam int COS_N        = 256;
    localparam int COLOR_BITS   = 32;
    localparam int NUM_COLORS   = 3;
    localparam int RATIO_BITS   = 16;   // Q15, one = 32768
    localparam int IDX_BITS     = $clog2(COS_N);
    localparam int CH_PER_WORD  = COLOR_BITS / CHANNEL_BITS;
    localparam int CH_IDX_BITS  = (CH_PER_WORD > 1) ? $clog2(CH_PER_WORD) : 1;
    localparam int REG_IDX_BITS = 3;
    localparam int DELTA_BITS   = 16;
    localparam int ELAPSED_BITS = 32;
    localparam int PROD_W       = CHANNEL_BITS + 18;

    // divider dividend width covers elapsed, phase << IDX_BITS and time << 15
    localparam int DIV_A = (TIME_BITS + 16 > ELAPSED_BITS) ? TIME_BITS + 16 : ELAPSED_BITS;
    localparam int DIV_W = (TIME_BITS + IDX_BITS > DIV_A) ? TIME_BITS + IDX_BITS : DIV_A;
    localparam int DIV_CNT_BITS = $clog2(DIV_W + 1);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_LOAD  = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_TGT_DIFF  = 3'd0,
        REG_TGT_AMB   = 3'd1,
        REG_TGT_SPEC  = 3'd2,
        REG_TOTAL     = 3'd3,
        REG_FADE_IN   = 3'd4,
        REG_FADE_OUT  = 3'd5,
        REG_BLINK_CNT = 3'd6,
        REG_RETURN    = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        DIV_PER  = 3'd0,   // total / blink_count
        DIV_MOD  = 3'd1,   // elapsed mod period
        DIV_IDX  = 3'd2,   // phase * N / period
        DIV_FIN  = 3'd3,   // fade-in ratio
        DIV_FOUT = 3'd4    // fade-out ratio
    } t_div_sel;

    typedef struct packed {
        logic     capture;
        logic     tick_add;
        logic     start_snap;
        logic     load_colors;
        logic     finish;
        logic     div_go;
        t_div_sel div_sel;
        logic     set_dir;
        logic     dir;          // 1: start toward target
        logic     set_period;
        logic     set_ratio_cos;
        logic     set_ratio_div;
        logic     blend_step;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    active;
        logic    ge_total;
        logic    blink_mode;
        logic    le_fade_in;
        logic    fade_in_nz;
        logic    fout_ok;
        logic    blink_cnt_nz;
        logic    div_busy;
        logic    blend_last;
    } t_stat;

    function automatic logic [COS_N-1:0][15:0] gen_cos_table();
        logic [COS_N-1:0][15:0] tab;
        logic [63:0] j, x, x2, t, s, r;
        for (int i = 0; i < COS_N; i++) begin
            j = 64'(i);
            if (64'd2 * j > 64'(COS_N)) begin
                j = 64'(COS_N) - j;
            end
            x  = 64'd3373259426 * j / 64'(COS_N);
            x2 = (x * x) >> 30;
            t  = 64'd1073741824 - x2 / 64'd72;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            r  = (s * s) >> 30;
            r  = (r + 64'd16384) >> 15;
            if (r > 64'd32768) begin
                r = 64'd32768;
            end
            tab[i] = r[15:0];
        end
        return tab;
    endfunction

    localparam logic [COS_N-1:0][15:0] COS_TABLE = gen_cos_table();

endpackage

`default_nettype wire

// ===== design/lcfb_in_if.sv =====
// Input channel of the fade/blink engine: valid/ready handshake and the item payload.
// No dependencies.
`default_nettype none

interface lcfb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] time_delta;
    logic [31:0] load_diffuse;
    logic [31:0] load_ambient;
    logic [31:0] load_specular;

    modport source (output valid, action, time_delta, load_diffuse, load_ambient,
                    load_specular, input ready);
    modport sink   (input valid, action, time_delta, load_diffuse, load_ambient,
                    load_specular, output ready);
endinterface

`default_nettype wire

// ===== design/lcfb_out_if.sv =====
// Result channel of the fade/blink engine: valid/ready handshake and the result payload.
// No dependencies.
`default_nettype none

interface lcfb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_diffuse;
    logic [31:0] out_ambient;
    logic [31:0] out_specular;
    logic        running;
    logic        finished;

    modport source (output valid, out_diffuse, out_ambient, out_specular, running,
                    finished, input ready);
    modport sink   (input valid, out_diffuse, out_ambient, out_specular, running,
                    finished, output ready);
endinterface

`default_nettype wire

// ===== design/light_color_fade_blink_engine_unit.sv =====
// Top level of the light color fade/blink engine: ties sequencer, datapath and channels.
// Depends on lcfb_pkg, lcfb_in_if, lcfb_out_if, lcfb_ctrl and lcfb_dp.
`default_nettype none

// Keeps three packed RGBA colors and runs fade or raised-cosine blink transitions toward
// the target colors held in eight config registers (written via i_cfg_we/idx/data while
// idle, a rule for the user that the block itself does not enforce). Each input transfer
// (tick, start, load, nop) yields exactly one result transfer with the current colors,
// running and a one-shot finished flag. Items are handled one at a time: load, nop, an
// idle tick or an ignored start go from decode to the result stage; a finishing or
// holding tick passes a check stage as well; a start with a nonzero blink count takes one
// divide; a fade tick takes one divide and a blend; a blink tick takes two divides and a
// blend. The shared bit-serial divider (one quotient bit per cycle, 40-bit dividend) and
// the single channel blender (one 8-bit channel per cycle) set the length of each item.
// A finished result sits in an output register, so the next item is taken while it
// waits; processing of that item stalls only at its own result stage.
module light_color_fade_blink_engine_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    lcfb_in_if.sink                          i_in_ch,
    lcfb_out_if.source                       o_out_ch,
    input  wire                              i_cfg_we,
    input  wire [lcfb_pkg::REG_IDX_BITS-1:0] i_cfg_idx,
    input  wire [31:0]                       i_cfg_data
);
    import lcfb_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;
    logic  w_out_valid;

    lcfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out_ch.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    lcfb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_in_ch.action),
        .i_time_delta    (i_in_ch.time_delta),
        .i_load_diffuse  (i_in_ch.load_diffuse),
        .i_load_ambient  (i_in_ch.load_ambient),
        .i_load_specular (i_in_ch.load_specular),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_out_diffuse   (o_out_ch.out_diffuse),
        .o_out_ambient   (o_out_ch.out_ambient),
        .o_out_specular  (o_out_ch.out_specular),
        .o_running       (o_out_ch.running),
        .o_finished      (o_out_ch.finished)
    );

    assign i_in_ch.ready  = w_in_ready;
    assign o_out_ch.valid = w_out_valid;

    // finished always comes with the transition stopped
    a_fin_not_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && o_out_ch.finished) |-> !o_out_ch.running)
        else $error("finished reported while still running");

    // one item in flight: no transfer in the cycle after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && w_in_ready) |=> !w_in_ready)
        else $error("input taken while an item is in progress");

    // a new result only comes out of the result stage, never while idle
    a_result_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_out_valid) |-> $past(!w_in_ready))
        else $error("result issued without an item in progress");

    // the divider is never restarted while a divide is under way
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.div_busy |-> !w_cmd.div_go)
        else $error("divider restarted while busy");

endmodule

`default_nettype wire

// ===== design/lcfb_ctrl.sv =====
// Sequencer of the fade/blink engine: one-hot state machine issuing datapath commands.
// Depends on lcfb_pkg.
`default_nettype none

module lcfb_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  lcfb_pkg::t_stat   i_stat,
    output lcfb_pkg::t_cmd    o_cmd
);
    import lcfb_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DECODE    = 9'b000000010,
        S_CHECK     = 9'b000000100,
        S_DIV_PER   = 9'b000001000,
        S_DIV_MOD   = 9'b000010000,
        S_DIV_IDX   = 9'b000100000,
        S_DIV_RATIO = 9'b001000000,
        S_BLEND     = 9'b010000000,
        S_RESULT    = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RESULT;
                case (i_stat.action)
                    ACT_TICK: begin
                        if (i_stat.active) begin
                            o_cmd.tick_add = 1'b1;
                            n_state        = S_CHECK;
                        end
                    end
                    ACT_START: begin
                        if (!i_stat.active) begin
                            o_cmd.start_snap = 1'b1;
                            if (i_stat.blink_cnt_nz) begin
                                o_cmd.div_go  = 1'b1;
                                o_cmd.div_sel = DIV_PER;
                                n_state       = S_DIV_PER;
                            end
                        end
                    end
                    ACT_LOAD: o_cmd.load_colors = 1'b1;
                    default: ;
                endcase
            end
            S_CHECK: begin
                n_state = S_RESULT;
                if (i_stat.ge_total) begin
                    o_cmd.finish = 1'b1;
                end else if (i_stat.blink_mode) begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = DIV_MOD;
                    o_cmd.set_dir = 1'b1;
                    o_cmd.dir     = 1'b1;
                    n_state       = S_DIV_MOD;
                end else if (i_stat.le_fade_in) begin
                    if (i_stat.fade_in_nz) begin
                        o_cmd.div_go  = 1'b1;
                        o_cmd.div_sel = DIV_FIN;
                        o_cmd.set_dir = 1'b1;
                        o_cmd.dir     = 1'b1;
                        n_state       = S_DIV_RATIO;
                    end
                end else if (i_stat.fout_ok) begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = DIV_FOUT;
                    o_cmd.set_dir = 1'b1;
                    o_cmd.dir     = 1'b0;
                    n_state       = S_DIV_RATIO;
                end
            end
            S_DIV_PER: begin
                if (!i_stat.div_busy) begin
                    o_cmd.set_period = 1'b1;
                    n_state          = S_RESULT;
                end
            end
            S_DIV_MOD: begin
                if (!i_stat.div_busy) begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = DIV_IDX;
                    n_state       = S_DIV_IDX;
                end
            end
            S_DIV_IDX: begin
                if (!i_stat.div_busy) begin
                    o_cmd.set_ratio_cos = 1'b1;
                    n_state             = S_BLEND;
                end
            end
            S_DIV_RATIO: begin
                if (!i_stat.div_busy) begin
                    o_cmd.set_ratio_div = 1'b1;
                    n_state             = S_BLEND;
                end
            end
            S_BLEND: begin
                o_cmd.blend_step = 1'b1;
                if (i_stat.blend_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== design/lcfb_dp.sv =====
// Datapath of the fade/blink engine: registers, state, shared divider and channel blender.
// Depends on lcfb_pkg.
`default_nettype none

module lcfb_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [lcfb_pkg::REG_IDX_BITS-1:0] i_cfg_idx,
    input  wire [31:0]                   i_cfg_data,
    input  wire [1:0]                    i_action,
    input  wire [15:0]                   i_time_delta,
    input  wire [31:0]                   i_load_diffuse,
    input  wire [31:0]                   i_load_ambient,
    input  wire [31:0]                   i_load_specular,
    input  lcfb_pkg::t_cmd               i_cmd,
    output lcfb_pkg::t_stat              o_stat,
    output logic [31:0]                  o_out_diffuse,
    output logic [31:0]                  o_out_ambient,
    output logic [31:0]                  o_out_specular,
    output logic                         o_running,
    output logic                         o_finished
);
    import lcfb_pkg::*;

    // configuration
    logic [COLOR_BITS-1:0] r_tgt [NUM_COLORS];
    logic [TIME_BITS-1:0]  r_total, r_fade_in, r_fade_out;
    logic [7:0]            r_blink_cnt;
    logic                  r_return;

    // captured item
    t_action               r_action;
    logic [DELTA_BITS-1:0] r_delta;
    logic [COLOR_BITS-1:0] r_load [NUM_COLORS];

    // engine state
    logic [COLOR_BITS-1:0]   r_cur [NUM_COLORS];
    logic [COLOR_BITS-1:0]   r_start [NUM_COLORS];
    logic [ELAPSED_BITS-1:0] r_elapsed;
    logic [TIME_BITS-1:0]    r_period;
    logic                    r_active;
    logic                    r_fin;

    // divider
    logic [DIV_W-1:0]        r_dquo;
    logic [TIME_BITS-1:0]    r_drem, r_ddiv;
    logic [DIV_CNT_BITS-1:0] r_dcnt;
    logic                    r_dbusy;

    // blender
    logic [RATIO_BITS-1:0]   r_ratio;
    logic                    r_dir;
    logic [1:0]              r_bcol;
    logic [CH_IDX_BITS-1:0]  r_bch;

    // output register
    logic [COLOR_BITS-1:0] r_out [NUM_COLORS];
    logic                  r_out_run, r_out_fin;

    logic [ELAPSED_BITS:0]   w_sum;
    logic [TIME_BITS-1:0]    w_begin, w_len, w_fdiff;
    logic [DIV_W-1:0]        w_dividend;
    logic [TIME_BITS-1:0]    w_divisor;
    logic [TIME_BITS:0]      w_rsh;
    logic                    w_qbit;
    logic [COLOR_BITS-1:0]   w_a, w_b, w_word;
    logic [CHANNEL_BITS-1:0] w_ca, w_cb, w_v;
    logic [CHANNEL_BITS:0]   w_diff;
    logic [PROD_W-1:0]       w_prod, w_acc;
    logic                    w_ch_last;

    assign w_sum   = {1'b0, r_elapsed} + ELAPSED_BITS'(r_delta);
    assign w_begin = (r_fade_out > r_total) ? '0 : r_total - r_fade_out;
    assign w_len   = r_total - w_begin;
    assign w_fdiff = r_elapsed[TIME_BITS-1:0] - w_begin;

    assign o_stat.action       = r_action;
    assign o_stat.active       = r_active;
    assign o_stat.ge_total     = (r_elapsed >= ELAPSED_BITS'(r_total));
    assign o_stat.blink_mode   = (r_blink_cnt != '0) && (r_period != '0);
    assign o_stat.le_fade_in   = (r_elapsed <= ELAPSED_BITS'(r_fade_in));
    assign o_stat.fade_in_nz   = (r_fade_in != '0);
    assign o_stat.fout_ok      = r_return && (r_elapsed >= ELAPSED_BITS'(w_begin))
                                 && (w_len != '0);
    assign o_stat.blink_cnt_nz = (r_blink_cnt != '0);
    assign o_stat.div_busy     = r_dbusy;
    assign w_ch_last           = (r_bch == CH_IDX_BITS'(CH_PER_WORD - 1));
    assign o_stat.blend_last   = w_ch_last && (r_bcol == 2'(NUM_COLORS - 1));

    // divider operand selection
    always_comb begin
        case (i_cmd.div_sel)
            DIV_PER: begin
                w_dividend = DIV_W'(r_total);
                w_divisor  = TIME_BITS'(r_blink_cnt);
            end
            DIV_MOD: begin
                w_dividend = DIV_W'(r_elapsed);
                w_divisor  = r_period;
            end
            DIV_IDX: begin
                w_dividend = DIV_W'({r_drem, {IDX_BITS{1'b0}}});
                w_divisor  = r_period;
            end
            DIV_FIN: begin
                w_dividend = DIV_W'({r_elapsed[TIME_BITS-1:0], 15'd0});
                w_divisor  = r_fade_in;
            end
            DIV_FOUT: begin
                w_dividend = DIV_W'({w_fdiff, 15'd0});
                w_divisor  = w_len;
            end
            default: begin
                w_dividend = '0;
                w_divisor  = r_period;
            end
        endcase
    end

    // restoring step, one quotient bit per cycle
    assign w_rsh  = {r_drem, r_dquo[DIV_W-1]};
    assign w_qbit = (w_rsh >= {1'b0, r_ddiv});

    // channel blend: a + (b - a) * r, rounded, Q15
    always_comb begin
        w_a    = r_dir ? r_start[r_bcol] : r_tgt[r_bcol];
        w_b    = r_dir ? r_tgt[r_bcol]   : r_start[r_bcol];
        w_ca   = CHANNEL_BITS'(w_a >> (r_bch * CHANNEL_BITS));
        w_cb   = CHANNEL_BITS'(w_b >> (r_bch * CHANNEL_BITS));
        w_diff = {1'b0, w_cb} - {1'b0, w_ca};
        w_prod = PROD_W'($signed(PROD_W'($signed(w_diff)))
                         * $signed(PROD_W'({1'b0, r_ratio})));
        w_acc  = w_prod + PROD_W'({w_ca, 15'd0}) + PROD_W'(17'd16384);
        w_v    = w_acc[15 +: CHANNEL_BITS];
        w_word = (r_bch == '0) ? '0 : r_cur[r_bcol];
        w_word[r_bch * CHANNEL_BITS +: CHANNEL_BITS] = w_v;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COLORS; k++) begin
                r_tgt[k]   <= '0;
                r_cur[k]   <= '0;
                r_start[k] <= '0;
            end
            r_total     <= '0;
            r_fade_in   <= '0;
            r_fade_out  <= '0;
            r_blink_cnt <= '0;
            r_return    <= 1'b0;
            r_elapsed   <= '0;
            r_period    <= '0;
            r_active    <= 1'b0;
            r_fin       <= 1'b0;
            r_dbusy     <= 1'b0;
            r_dcnt      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_TGT_DIFF:  r_tgt[0]    <= i_cfg_data;
                    REG_TGT_AMB:   r_tgt[1]    <= i_cfg_data;
                    REG_TGT_SPEC:  r_tgt[2]    <= i_cfg_data;
                    REG_TOTAL:     r_total     <= i_cfg_data[TIME_BITS-1:0];
                    REG_FADE_IN:   r_fade_in   <= i_cfg_data[TIME_BITS-1:0];
                    REG_FADE_OUT:  r_fade_out  <= i_cfg_data[TIME_BITS-1:0];
                    REG_BLINK_CNT: r_blink_cnt <= i_cfg_data[7:0];
                    REG_RETURN:    r_return    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.capture) begin
                r_fin <= 1'b0;
            end
            if (i_cmd.tick_add) begin
                r_elapsed <= w_sum[ELAPSED_BITS] ? '1 : w_sum[ELAPSED_BITS-1:0];
            end
            if (i_cmd.start_snap) begin
                for (int k = 0; k < NUM_COLORS; k++) begin
                    r_start[k] <= r_cur[k];
                end
                r_active  <= 1'b1;
                r_elapsed <= '0;
            end
            if (i_cmd.load_colors) begin
                for (int k = 0; k < NUM_COLORS; k++) begin
                    r_cur[k] <= r_load[k];
                end
            end
            if (i_cmd.finish) begin
                for (int k = 0; k < NUM_COLORS; k++) begin
                    r_cur[k] <= r_return ? r_start[k] : r_tgt[k];
                end
                r_period <= '0;
                r_active <= 1'b0;
                r_fin    <= 1'b1;
            end
            if (i_cmd.set_period) begin
                r_period <= r_dquo[TIME_BITS-1:0];
            end
            if (i_cmd.blend_step) begin
                r_cur[r_bcol] <= w_word;
            end
            if (i_cmd.div_go) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= DIV_CNT_BITS'(DIV_W);
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == DIV_CNT_BITS'(1)) begin
                    r_dbusy <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= t_action'(i_action);
            r_delta  <= i_time_delta;
            r_load[0] <= i_load_diffuse;
            r_load[1] <= i_load_ambient;
            r_load[2] <= i_load_specular;
        end
        if (i_cmd.div_go) begin
            r_dquo <= w_dividend;
            r_drem <= '0;
            r_ddiv <= w_divisor;
        end else if (r_dbusy) begin
            r_dquo <= {r_dquo[DIV_W-2:0], w_qbit};
            r_drem <= w_qbit ? TIME_BITS'(w_rsh - {1'b0, r_ddiv}) : w_rsh[TIME_BITS-1:0];
        end
        if (i_cmd.set_dir) begin
            r_dir <= i_cmd.dir;
        end
        if (i_cmd.set_ratio_cos || i_cmd.set_ratio_div) begin
            r_ratio <= i_cmd.set_ratio_cos ? COS_TABLE[r_dquo[IDX_BITS-1:0]]
                                           : r_dquo[RATIO_BITS-1:0];
            r_bcol  <= '0;
            r_bch   <= '0;
        end else if (i_cmd.blend_step) begin
            if (w_ch_last) begin
                r_bch  <= '0;
                r_bcol <= r_bcol + 2'd1;
            end else begin
                r_bch <= r_bch + 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            for (int k = 0; k < NUM_COLORS; k++) begin
                r_out[k] <= r_cur[k];
            end
            r_out_run <= r_active;
            r_out_fin <= r_fin;
        end
    end

    assign o_out_diffuse  = r_out[0];
    assign o_out_ambient  = r_out[1];
    assign o_out_specular = r_out[2];
    assign o_running      = r_out_run;
    assign o_finished     = r_out_fin;

endmodule

`default_nettype wire
